@@ src/depth_temporal_persistence_filter_defines.svh @@
// assertion macros for the depth temporal persistence filter checker
// no dependencies; included by files that hold concurrent assertions
`ifndef DEPTH_TEMPORAL_PERSISTENCE_FILTER_DEFINES_SVH
`define DEPTH_TEMPORAL_PERSISTENCE_FILTER_DEFINES_SVH

// property checked only outside reset
`define DTPF_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define DTPF_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/dtpf_pkg.sv @@
// shared types, constants and the hole fill vote function
// for the depth temporal persistence filter; no dependencies
`default_nettype none

package dtpf_pkg;

  localparam int unsigned MAX_PIXELS_DEF = 1048576;
  localparam int unsigned VAL_W  = 16;
  localparam int unsigned HIST_W = 8;

  // register indexes on the configuration port
  localparam logic [1:0] REG_BLEND_WEIGHT     = 2'd0;
  localparam logic [1:0] REG_AGREE_THRESHOLD  = 2'd1;
  localparam logic [1:0] REG_PERSISTENCE_MODE = 2'd2;

  localparam logic [8:0] BLEND_WEIGHT_RST     = 9'd102;
  localparam logic [7:0] AGREE_THRESHOLD_RST  = 8'd20;
  localparam logic [3:0] PERSISTENCE_MODE_RST = 4'd0;
  localparam logic [8:0] BLEND_ONE            = 9'd256;

  // hole fill rules
  localparam logic [3:0] MODE_NONE     = 4'd0;
  localparam logic [3:0] MODE_ALL8     = 4'd1;
  localparam logic [3:0] MODE_2_OF_3   = 4'd2;
  localparam logic [3:0] MODE_2_OF_4   = 4'd3;
  localparam logic [3:0] MODE_2_OF_8   = 4'd4;
  localparam logic [3:0] MODE_1_OF_2   = 4'd5;
  localparam logic [3:0] MODE_1_OF_5   = 4'd6;
  localparam logic [3:0] MODE_1_OF_8   = 4'd7;
  localparam logic [3:0] MODE_ALWAYS   = 4'd8;

  typedef struct packed {
    logic [8:0] blend_weight;
    logic [7:0] agree_threshold;
    logic [3:0] persistence_mode;
  } cfg_t;

  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic [HIST_W-1:0] hist;
  } entry_t;

  // number of set bits among the top nbits of r (bit 7 newest)
  function automatic logic [3:0] count_top(logic [7:0] r, int unsigned nbits);
    logic [3:0] n;
    n = 4'd0;
    for (int k = 0; k < 8; k++) begin
      if (k < nbits) begin
        n = n + 4'(r[7-k]);
      end
    end
    return n;
  endfunction

  function automatic logic rule_accepts(logic [3:0] mode, logic [7:0] r);
    logic ok;
    case (mode)
      MODE_ALL8:   ok = (count_top(r, 8) >= 4'd8);
      MODE_2_OF_3: ok = (count_top(r, 3) >= 4'd2);
      MODE_2_OF_4: ok = (count_top(r, 4) >= 4'd2);
      MODE_2_OF_8: ok = (count_top(r, 8) >= 4'd2);
      MODE_1_OF_2: ok = (count_top(r, 2) >= 4'd1);
      MODE_1_OF_5: ok = (count_top(r, 5) >= 4'd1);
      MODE_1_OF_8: ok = (count_top(r, 8) >= 4'd1);
      MODE_ALWAYS: ok = 1'b1;
      default:     ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

`default_nettype wire

@@ src/depth_temporal_persistence_filter.sv @@
// top level of the depth temporal persistence filter: position and phase
// tracking, read-modify-write pipeline, clearing pass, configuration registers
// uses dtpf_pkg, dtpf_store, dtpf_update
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid_i in_ready_o disparity_in_i frame_end_i | sink
//  out     | out_valid_o out_ready_i disparity_out_o          | source
//          | frame_end_out_o overrun_o                        |
//  cfg     | cfg_valid_i cfg_ready_o cfg_index_i cfg_wdata_i  | sink
//
// one pixel per cycle sustained while the output accepts and no clearing pass runs; a pixel
// goes from the b stage (registered store read, update) to the output register, written back as it moves
// a one-pixel frame makes neighbors hit the same entry; the write data is forwarded
// after reset and after a write that changes a register the store is zeroed,
// one entry per cycle over all MAX_PIXELS entries, with in_ready_o low
// a stalled output holds the update stage; input stalls only when both are full or while clearing
`default_nettype none

module depth_temporal_persistence_filter #(
  parameter int unsigned MAX_PIXELS = dtpf_pkg::MAX_PIXELS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] disparity_in_i,
  input  wire logic        frame_end_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      disparity_out_o,
  output logic             frame_end_out_o,
  output logic             overrun_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [8:0]  cfg_wdata_i
);
  import dtpf_pkg::*;

  localparam int unsigned AW = $clog2(MAX_PIXELS);
  localparam int unsigned PW = $clog2(MAX_PIXELS + 1);
  localparam logic [PW-1:0] POS_LIMIT = PW'(MAX_PIXELS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_PIXELS - 1);

  cfg_t          cfg_q, cfg_d;
  logic          clear_q, clear_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [2:0]    phase_q, phase_d;

  logic          b_valid_q;
  logic [15:0]   b_cur_q;
  logic          b_fend_q;
  logic          b_ovr_q;
  logic [AW-1:0] b_addr_q;
  logic [2:0]    b_phase_q;
  logic          fwd_q;
  entry_t        fwd_data_q;

  logic          out_valid_q;
  logic [15:0]   out_disp_q;
  logic          out_fend_q;
  logic          out_ovr_q;

  logic          in_acc;
  logic          cfg_acc;
  logic          cfg_change;
  logic          b_adv;
  logic          ovr_a;
  logic [AW-1:0] raddr;
  logic          fwd_d;
  entry_t        rdata;
  entry_t        old_entry;
  entry_t        new_entry;
  logic [15:0]   upd_result;
  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;

  assign in_acc  = in_valid_i && in_ready_o;
  assign cfg_acc = cfg_valid_i && cfg_ready_o;
  assign b_adv   = b_valid_q && (!out_valid_q || out_ready_i);

  assign in_ready_o  = !clear_q && (!b_valid_q || b_adv);
  assign cfg_ready_o = 1'b1;

  assign ovr_a = (pos_q >= POS_LIMIT);
  assign raddr = pos_q[AW-1:0];

  // previous pixel writes the entry this one reads
  assign fwd_d = b_adv && !b_ovr_q && (b_addr_q == raddr);

  assign old_entry = fwd_q ? fwd_data_q : rdata;

  always_comb begin
    we    = 1'b0;
    waddr = b_addr_q;
    wdata = new_entry;
    if (clear_q) begin
      we    = 1'b1;
      waddr = clr_cnt_q;
      wdata = '0;
    end else if (b_adv && !b_ovr_q) begin
      we = 1'b1;
    end
  end

  dtpf_store #(
    .DEPTH (MAX_PIXELS),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .rd_en_i (in_acc),
    .raddr_i (raddr),
    .rdata_o (rdata),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata)
  );

  dtpf_update u_update (
    .cfg_i    (cfg_q),
    .cur_i    (b_cur_q),
    .phase_i  (b_phase_q),
    .old_i    (old_entry),
    .result_o (upd_result),
    .new_o    (new_entry)
  );

  // configuration, clearing pass, position and phase
  always_comb begin
    cfg_d      = cfg_q;
    cfg_change = 1'b0;
    if (cfg_acc) begin
      case (cfg_index_i)
        REG_BLEND_WEIGHT: begin
          cfg_d.blend_weight = cfg_wdata_i;
          cfg_change = (cfg_q.blend_weight != cfg_wdata_i);
        end
        REG_AGREE_THRESHOLD: begin
          cfg_d.agree_threshold = cfg_wdata_i[7:0];
          cfg_change = (cfg_q.agree_threshold != cfg_wdata_i[7:0]);
        end
        REG_PERSISTENCE_MODE: begin
          cfg_d.persistence_mode = cfg_wdata_i[3:0];
          cfg_change = (cfg_q.persistence_mode != cfg_wdata_i[3:0]);
        end
        default: begin
          cfg_change = 1'b0;
        end
      endcase
    end

    clear_d   = clear_q;
    clr_cnt_d = clr_cnt_q;
    if (cfg_change) begin
      clear_d   = 1'b1;
      clr_cnt_d = '0;
    end else if (clear_q) begin
      if (clr_cnt_q == LAST_ADDR) begin
        clear_d = 1'b0;
      end else begin
        clr_cnt_d = clr_cnt_q + AW'(1);
      end
    end

    pos_d   = pos_q;
    phase_d = phase_q;
    if (in_acc) begin
      if (frame_end_i) begin
        pos_d   = '0;
        phase_d = phase_q + 3'd1;
      end else if (!ovr_a) begin
        pos_d = pos_q + PW'(1);
      end
    end
    if (cfg_change) begin
      phase_d = 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.blend_weight     <= BLEND_WEIGHT_RST;
      cfg_q.agree_threshold  <= AGREE_THRESHOLD_RST;
      cfg_q.persistence_mode <= PERSISTENCE_MODE_RST;
      clear_q     <= 1'b1;
      clr_cnt_q   <= '0;
      pos_q       <= '0;
      phase_q     <= 3'd0;
      b_valid_q   <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cfg_q     <= cfg_d;
      clear_q   <= clear_d;
      clr_cnt_q <= clr_cnt_d;
      pos_q     <= pos_d;
      phase_q   <= phase_d;
      if (in_acc) begin
        b_valid_q <= 1'b1;
        fwd_q     <= fwd_d;
      end else if (b_adv) begin
        b_valid_q <= 1'b0;
      end
      if (b_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      b_cur_q    <= disparity_in_i;
      b_fend_q   <= frame_end_i;
      b_ovr_q    <= ovr_a;
      b_addr_q   <= raddr;
      b_phase_q  <= phase_q;
      fwd_data_q <= new_entry;
    end
    if (b_adv) begin
      out_disp_q <= b_ovr_q ? b_cur_q : upd_result;
      out_fend_q <= b_fend_q;
      out_ovr_q  <= b_ovr_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign disparity_out_o = out_disp_q;
  assign frame_end_out_o = out_fend_q;
  assign overrun_o       = out_ovr_q;

endmodule

`default_nettype wire

@@ src/dtpf_store.sv @@
// per pixel store: last value and validity history, one write port,
// one read port with registered data; uses dtpf_pkg
`default_nettype none

module dtpf_store #(
  parameter int unsigned DEPTH = dtpf_pkg::MAX_PIXELS_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    raddr_i,
  output dtpf_pkg::entry_t      rdata_o,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  dtpf_pkg::entry_t      wdata_i
);
  import dtpf_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ src/dtpf_update.sv @@
// per pixel update: agreement test, blend, hole fill vote, history update
// combinational; uses dtpf_pkg
`default_nettype none

module dtpf_update (
  input  dtpf_pkg::cfg_t        cfg_i,
  input  wire logic [15:0]      cur_i,
  input  wire logic [2:0]       phase_i,
  input  dtpf_pkg::entry_t      old_i,
  output logic [15:0]           result_o,
  output dtpf_pkg::entry_t      new_o
);
  import dtpf_pkg::*;

  logic [15:0]        prev;
  logic [7:0]         hist;
  logic [7:0]         mask;
  logic [15:0]        diff;
  logic               agree;
  logic [8:0]         w_eff;
  logic [16:0]        d_full;
  logic signed [18:0] prod;
  logic signed [18:0] step;
  logic [16:0]        mix;
  logic [15:0]        hh;
  logic [7:0]         rot;

  assign prev = old_i.value;
  assign hist = old_i.hist;
  assign mask = 8'b1 << phase_i;

  assign diff  = (cur_i > prev) ? (cur_i - prev) : (prev - cur_i);
  assign agree = (prev != 16'd0) && (diff < {8'd0, cfg_i.agree_threshold});

  // weights above one saturate at one
  assign w_eff = (cfg_i.blend_weight > BLEND_ONE) ? BLEND_ONE : cfg_i.blend_weight;

  // w*cur + (256-w)*prev = 256*prev + w*(cur-prev); agreement keeps |cur-prev| < 256
  assign d_full = {1'b0, cur_i} - {1'b0, prev};
  assign prod   = $signed({10'd0, w_eff}) * $signed({{10{d_full[8]}}, d_full[8:0]});
  assign step   = prod >>> 8;
  assign mix    = {1'b0, prev} + step[16:0];

  // history rotated right by the phase
  assign hh  = {hist, hist} >> phase_i;
  assign rot = hh[7:0];

  always_comb begin
    result_o = cur_i;
    new_o    = old_i;
    if (cur_i != 16'd0) begin
      if (agree) begin
        result_o    = mix[15:0];
        new_o.value = mix[15:0];
        new_o.hist  = hist | mask;
      end else begin
        new_o.value = cur_i;
        new_o.hist  = mask;
      end
    end else begin
      if ((prev != 16'd0) && rule_accepts(cfg_i.persistence_mode, rot)) begin
        result_o = prev;
      end
      new_o.hist = hist & ~mask;
    end
  end

endmodule

`default_nettype wire

@@ src/dtpf_checker.sv @@
// port level checks for the depth temporal persistence filter, bound to the top
// uses depth_temporal_persistence_filter_defines.svh
`default_nettype none
`include "depth_temporal_persistence_filter_defines.svh"

module dtpf_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [15:0] disparity_in_i,
  input wire logic        frame_end_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [15:0] disparity_out_o,
  input wire logic        frame_end_out_o,
  input wire logic        overrun_o,
  input wire logic        cfg_valid_i,
  input wire logic        cfg_ready_o,
  input wire logic [1:0]  cfg_index_i,
  input wire logic [8:0]  cfg_wdata_i
);

  logic in_acc;
  logic unused_ok;

  assign in_acc    = in_valid_i && in_ready_o;
  assign unused_ok = ^{disparity_in_i, frame_end_i, cfg_valid_i, cfg_ready_o,
                       cfg_index_i, cfg_wdata_i};

  // a stalled result holds
  `DTPF_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(disparity_out_o) && $stable(frame_end_out_o) && $stable(overrun_o), "stalled result changed")

  // after each accepted pixel the output register holds a result, its own or a stalled one
  `DTPF_ASSERT(a_latency, clk_i, rst_ni, in_acc |-> ##2 out_valid_o, "result missing after two cycles")

  // no result shows during reset
  `DTPF_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |-> !out_valid_o, "result valid in reset")

  // the store clear keeps input closed right after reset
  `DTPF_ASSERT_ALWAYS(a_clear_after_rst, clk_i, $rose(rst_ni) |-> !in_ready_o, "input open during store clear")

endmodule

bind depth_temporal_persistence_filter dtpf_checker u_dtpf_checker (.*);

`default_nettype wire

@@ tb/depth_temporal_persistence_filter_tb.sv @@
// self-checking testbench for the depth temporal persistence filter
// depends on dtpf_pkg and depth_temporal_persistence_filter; pixel streams are
// checked against a scoreboard that tracks the stores, phase and registers
`default_nettype none

module depth_temporal_persistence_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dtpf_pkg::*;

  localparam int unsigned STORE_DEPTH = 64;
  localparam int unsigned CLK_PERIOD  = 20;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned NUM_PHASES  = 16;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam logic [1:0]  REG_UNUSED  = 2'd3;

  typedef struct packed {
    logic [15:0] disparity;
    logic        frame_end;
    logic        overrun;
  } pixel_t;

  class pixel_scoreboard;
    logic [15:0] stored_value [STORE_DEPTH];
    logic [7:0]  valid_hist [STORE_DEPTH];
    int unsigned position;
    logic [2:0]  phase;
    logic [8:0]  weight;
    logic [7:0]  thresh;
    logic [3:0]  mode;
    pixel_t      expected_pixels[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned blended;
    int unsigned filled;
    int unsigned overruns;

    function new();
      weight     = BLEND_WEIGHT_RST;
      thresh     = AGREE_THRESHOLD_RST;
      mode       = PERSISTENCE_MODE_RST;
      position   = 0;
      mismatches = 0;
      checked    = 0;
      blended    = 0;
      filled     = 0;
      overruns   = 0;
      clear_stores();
    endfunction

    function void clear_stores();
      for (int i = 0; i < STORE_DEPTH; i++) begin
        stored_value[i] = '0;
        valid_hist[i]   = '0;
      end
      phase = '0;
    endfunction

    // a write only takes effect (and wipes the stores) when the value changes
    function void apply_write(logic [1:0] idx, logic [8:0] data);
      case (idx)
        REG_BLEND_WEIGHT: begin
          if (weight != data) begin
            weight = data;
            clear_stores();
          end
        end
        REG_AGREE_THRESHOLD: begin
          if (thresh != data[7:0]) begin
            thresh = data[7:0];
            clear_stores();
          end
        end
        REG_PERSISTENCE_MODE: begin
          if (mode != data[3:0]) begin
            mode = data[3:0];
            clear_stores();
          end
        end
        default: begin
        end
      endcase
    endfunction

    // r has the newest frame in bit 7
    function bit hole_vote(logic [7:0] r);
      bit ok;
      case (mode)
        MODE_ALL8:   ok = (r == 8'hFF);
        MODE_2_OF_3: ok = ($countones(r & 8'hE0) >= 2);
        MODE_2_OF_4: ok = ($countones(r & 8'hF0) >= 2);
        MODE_2_OF_8: ok = ($countones(r) >= 2);
        MODE_1_OF_2: ok = ((r & 8'hC0) != 8'h00);
        MODE_1_OF_5: ok = ((r & 8'hF8) != 8'h00);
        MODE_1_OF_8: ok = (r != 8'h00);
        MODE_ALWAYS: ok = 1'b1;
        default:     ok = 1'b0;
      endcase
      return ok;
    endfunction

    function void note_pixel(logic [15:0] cur, logic fe);
      pixel_t      px;
      int unsigned p;
      int unsigned diff;
      int unsigned w;
      int unsigned mix;
      logic [15:0] prev;
      logic [7:0]  h;
      logic [7:0]  bitmask;
      logic [15:0] doubled;
      px.disparity = cur;
      px.frame_end = fe;
      px.overrun   = 1'b0;
      bitmask      = 8'h01 << phase;
      if (position >= STORE_DEPTH) begin
        px.overrun = 1'b1;
        overruns++;
      end else begin
        p    = position;
        prev = stored_value[p];
        h    = valid_hist[p];
        if (cur != 16'd0) begin
          diff = (cur > prev) ? (cur - prev) : (prev - cur);
          if (prev != 16'd0 && diff < thresh) begin
            w   = (weight > BLEND_ONE) ? BLEND_ONE : weight;
            mix = (w * cur + (256 - w) * prev) >> 8;
            px.disparity    = mix[15:0];
            stored_value[p] = mix[15:0];
            valid_hist[p]   = h | bitmask;
            blended++;
          end else begin
            stored_value[p] = cur;
            valid_hist[p]   = bitmask;
          end
        end else begin
          // history rotated right by the phase
          doubled = {h, h} >> phase;
          if (prev != 16'd0 && hole_vote(doubled[7:0])) begin
            px.disparity = prev;
            filled++;
          end
          valid_hist[p] = h & ~bitmask;
        end
        position = p + 1;
      end
      if (fe) begin
        position = 0;
        phase    = phase + 3'd1;
      end
      expected_pixels.insert(expected_pixels.size(), px);
    endfunction

    function void check_pixel(logic [15:0] disp, logic fe, logic ovr);
      pixel_t exp_px;
      checked++;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected pixel: disparity %h frame_end %b overrun %b", disp, fe, ovr);
        end
      end else begin
        exp_px = expected_pixels.pop_front();
        if (exp_px.disparity !== disp || exp_px.frame_end !== fe || exp_px.overrun !== ovr) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("pixel %0d: expected disparity %h frame_end %b overrun %b, got %h %b %b",
                     checked, exp_px.disparity, exp_px.frame_end, exp_px.overrun,
                     disp, fe, ovr);
          end
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [15:0] disparity_in_i;
  logic        frame_end_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] disparity_out_o;
  logic        frame_end_out_o;
  logic        overrun_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [8:0]  cfg_wdata_i;

  pixel_scoreboard sb;
  int unsigned     cycles;
  int unsigned     cfg_writes;
  bit              quiet;
  bit              tx_gaps;
  bit              rx_gaps;
  bit              hold_off_req;
  bit              force_long;
  int unsigned     hole_pct;
  int unsigned     frame_len;
  int unsigned     frame_pos;
  int              base_value [STORE_DEPTH + 16];

  depth_temporal_persistence_filter #(
    .MAX_PIXELS(STORE_DEPTH)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .disparity_in_i (disparity_in_i),
    .frame_end_i    (frame_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .disparity_out_o(disparity_out_o),
    .frame_end_out_o(frame_end_out_o),
    .overrun_o      (overrun_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels pending", cycles,
               sb.expected_pixels.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_pixel(disparity_out_o, frame_end_out_o, overrun_o);
    end
  end

  // output side: random stalls, one long hold-off on request
  initial begin
    out_ready_i <= 1'b0;
    wait (rst_ni);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (!quiet && rx_gaps && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // leaves in_valid_i high; the caller lowers it
  task automatic send_pixel(input logic [15:0] d, input logic fe);
    in_valid_i     <= 1'b1;
    disparity_in_i <= d;
    frame_end_i    <= fe;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_pixel(d, fe);
  endtask

  // leaves cfg_valid_i high; the caller lowers it
  task automatic program_reg(input logic [1:0] idx, input logic [8:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.apply_write(idx, data);
    cfg_writes++;
  endtask

  task automatic wait_drained();
    while (sb.expected_pixels.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // raster stream: mostly repeated frames with values near the last ones,
  // some holes, some jumps, the odd early frame end and long frames
  task automatic next_pixel(output logic [15:0] d, output logic fe);
    int r;
    int v;
    int j;
    if (frame_pos == 0) begin
      if (force_long) begin
        frame_len  = STORE_DEPTH + $urandom_range(1, 6);
        force_long = 1'b0;
      end else if (frame_len > STORE_DEPTH || $urandom_range(0, 9) == 0) begin
        frame_len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 8);
      end
    end
    r = $urandom_range(0, 99);
    j = int'(sb.thresh >> 1) + 1;
    if (r < hole_pct) begin
      v = 0;
    end else if (r < hole_pct + 8) begin
      v = $urandom_range(1, 65535);
    end else if (r < hole_pct + 11) begin
      v = r[0] ? 65535 : 1;
    end else begin
      v = base_value[frame_pos] + int'($urandom_range(0, 2 * j)) - j;
      if (v < 1) v = 1;
      if (v > 65535) v = 65535;
    end
    if (v != 0) base_value[frame_pos] = v;
    fe = (frame_pos + 1 >= frame_len) || ($urandom_range(0, 49) == 0);
    frame_pos = fe ? 0 : frame_pos + 1;
    d = v[15:0];
  endtask

  initial begin
    logic [15:0] dir_disp [13];
    logic        dir_fe [13];
    logic [15:0] d;
    logic        fe;
    logic [8:0]  w_data;
    logic [8:0]  t_data;
    logic [8:0]  m_data;
    int unsigned n_items;

    sb           = new();
    cycles       = 0;
    cfg_writes   = 0;
    quiet        = 1'b0;
    tx_gaps      = 1'b1;
    rx_gaps      = 1'b1;
    hold_off_req = 1'b0;
    force_long   = 1'b0;
    hole_pct     = 20;
    frame_len    = 4;
    frame_pos    = 0;
    for (int i = 0; i < STORE_DEPTH + 16; i++) base_value[i] = $urandom_range(1, 65535);

    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    disparity_in_i <= '0;
    frame_end_i    <= 1'b0;
    cfg_valid_i    <= 1'b0;
    cfg_index_i    <= '0;
    cfg_wdata_i    <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // single-pixel frames first: store, blend near full scale, hole, jump, blend near zero,
    // then a short multi-pixel frame that is revisited with holes and blends
    dir_disp = '{16'hFFFF, 16'hFFF0, 16'h0000, 16'h0001, 16'h0002, 16'h8000, 16'h7FFF,
                 16'h5555, 16'hAAAA, 16'h0000, 16'h7FF0, 16'h0000, 16'hAAAB};
    dir_fe   = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0,
                 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};
    for (int i = 0; i < 13; i++) send_pixel(dir_disp[i], dir_fe[i]);
    in_valid_i <= 1'b0;

    for (int ph = 1; ph <= NUM_PHASES; ph++) begin
      wait_drained();
      case (ph)
        1:       w_data = 9'd0;
        2:       w_data = BLEND_ONE;
        3:       w_data = 9'd511;
        4:       w_data = 9'd257;
        5:       w_data = 9'd1;
        default: w_data = 9'($urandom_range(0, 511));
      endcase
      case (ph)
        1:       t_data[7:0] = 8'd0;
        2:       t_data[7:0] = 8'd255;
        3:       t_data[7:0] = 8'd1;
        default: t_data[7:0] = 8'($urandom_range(2, 80));
      endcase
      t_data[8] = 1'($urandom_range(0, 1));
      m_data    = {5'($urandom_range(0, 31)), 4'(ph - 1)};
      program_reg(REG_BLEND_WEIGHT, w_data);
      // an equal write must leave the stores alone
      if (ph[0]) program_reg(REG_BLEND_WEIGHT, w_data);
      program_reg(REG_UNUSED, 9'($urandom_range(0, 511)));
      program_reg(REG_AGREE_THRESHOLD, t_data);
      program_reg(REG_PERSISTENCE_MODE, m_data);
      cfg_valid_i <= 1'b0;

      quiet    = (ph > NUM_PHASES - 2);
      tx_gaps  = ($urandom_range(0, 2) != 0);
      rx_gaps  = ($urandom_range(0, 2) != 0);
      hole_pct = $urandom_range(5, 25);
      if (ph == 6) begin
        tx_gaps      = 1'b0;
        hold_off_req = 1'b1;
      end
      if (ph % 5 == 2) force_long = 1'b1;
      n_items = (ph % 5 == 2) ? 80 : 28;

      for (int k = 0; k < n_items; k++) begin
        if (!quiet && tx_gaps && $urandom_range(0, 5) == 0) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 16)) @(posedge clk_i);
        end
        next_pixel(d, fe);
        send_pixel(d, fe);
      end
      in_valid_i <= 1'b0;
    end

    while (sb.expected_pixels.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("%0d pixels checked over %0d register writes in %0d settings", sb.checked,
             cfg_writes, NUM_PHASES + 1);
    $display("%0d blends, %0d hole fills, %0d pixels past the store end", sb.blended,
             sb.filled, sb.overruns);
    if (sb.mismatches == 0 && sb.expected_pixels.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ depth_temporal_persistence_filter.f @@
+incdir+src
src/dtpf_pkg.sv
src/dtpf_store.sv
src/dtpf_update.sv
src/depth_temporal_persistence_filter.sv
src/dtpf_checker.sv
tb/depth_temporal_persistence_filter_tb.sv
